// ===== src/escc_pkg.sv =====
// shared types, constants and calendar helpers for the epoch/calendar converter
package escc_pkg;

  localparam logic [31:0] DAY_SECS      = 32'd86400;
  localparam logic [31:0] HOUR_SECS     = 32'd3600;
  localparam logic [31:0] MIN_SECS      = 32'd60;
  localparam logic [31:0] EPOCH_AT_2000 = 32'd946684800;
  localparam logic [31:0] EPOCH_AT_2070 = 32'd3155760000;
  localparam logic [31:0] YEAR_SECS     = 32'd31536000;
  localparam logic [31:0] LEAP_SECS     = 32'd31622400;
  localparam logic [6:0]  WINDOW_PIVOT  = 7'd70;
  localparam logic [3:0]  LAST_MONTH    = 4'd12;

  localparam logic [21:0] MON31_SECS = 22'd2678400;
  localparam logic [21:0] MON30_SECS = 22'd2592000;
  localparam logic [21:0] MON29_SECS = 22'd2505600;
  localparam logic [21:0] MON28_SECS = 22'd2419200;

  // each divide is a reciprocal-multiply quotient step, then a subtract step
  localparam logic [2:0] DIV_FIRST_STEP = 3'd1;

  // x / 86400 = (x >> 7) / 675, x below 32 days
  localparam logic [14:0] DAY_RECIP  = 15'd24856;  // 2^24 / 675 rounded up
  // x / 3600 = (x >> 4) / 225, x below one day
  localparam logic [12:0] HOUR_RECIP = 13'd4661;   // 2^20 / 225 rounded up
  // x / 60 = (x >> 2) / 15, x below one hour
  localparam logic [10:0] MIN_RECIP  = 11'd1093;   // 2^14 / 15 rounded up

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR_DN,
    OP_MON_DN,
    OP_DIV_DAY,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_YEAR_UP,
    OP_MON_UP,
    OP_ADD_DAY,
    OP_ADD_TIME
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] k;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic year_fit;
    logic mon_fit;
    logic yr_end;
    logic mon_end;
  } dp_stat_t;

  function automatic logic [31:0] year_len(input logic leap);
    return leap ? LEAP_SECS : YEAR_SECS;
  endfunction

  function automatic logic [21:0] month_len(input logic [3:0] m, input logic leap);
    logic [21:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = MON31_SECS;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = MON30_SECS;
      4'd2:                                       r = leap ? MON29_SECS : MON28_SECS;
      default:                                    r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/escc_dp.sv =====
// datapath: shared 32-bit accumulator, year/month counters, divide and output registers
module escc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  escc_pkg::dp_cmd_t dp_cmd_i,
  output escc_pkg::dp_stat_t dp_stat_o,
  input  logic              cmd_i,
  input  logic [31:0]       epoch_in_i,
  input  logic [6:0]        year_in_i,
  input  logic [3:0]        month_in_i,
  input  logic [4:0]        day_in_i,
  input  logic [4:0]        hour_in_i,
  input  logic [5:0]        minute_in_i,
  input  logic [5:0]        second_in_i,
  output logic [31:0]       epoch_out_o,
  output logic [6:0]        year_out_o,
  output logic [3:0]        month_out_o,
  output logic [4:0]        day_out_o,
  output logic [4:0]        hour_out_o,
  output logic [5:0]        minute_out_o,
  output logic [5:0]        second_out_o,
  output logic              range_error_o
);
  import escc_pkg::*;

  logic        cmd_q;
  logic        err_q;
  logic [31:0] acc_q, acc_d;
  logic [6:0]  yy_q, yy_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  dq_q, dq_d;
  logic [4:0]  hq_q, hq_d;
  logic [5:0]  mq_q, mq_d;
  logic [6:0]  year_in_q;
  logic [3:0]  month_in_q;
  logic [4:0]  day_in_q;
  logic [4:0]  hour_in_q;
  logic [5:0]  minute_in_q;
  logic [5:0]  second_in_q;

  logic        mon_leap;
  logic [31:0] ylen;
  logic [31:0] mlen;
  logic        quot_step;
  logic [29:0] day_prod;
  logic [25:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] day_term;
  logic [31:0] time_term;

  assign ylen     = year_len(yy_q[1:0] == 2'd0);
  assign mon_leap = cmd_q ? (year_in_q[1:0] == 2'd0) : (yy_q[1:0] == 2'd0);
  assign mlen     = {10'd0, month_len(mon_q, mon_leap)};

  // quotient estimates, exact over the accumulator range of each divide
  assign quot_step = (dp_cmd_i.k != 3'd0);
  assign day_prod  = {15'd0, acc_q[21:7]} * {15'd0, DAY_RECIP};
  assign hour_prod = {13'd0, acc_q[16:4]} * {13'd0, HOUR_RECIP};
  assign min_prod  = {11'd0, acc_q[11:2]} * {10'd0, MIN_RECIP};

  assign day_term  = (DAY_SECS * {27'd0, day_in_q}) - DAY_SECS;
  assign time_term = (HOUR_SECS * {27'd0, hour_in_q}) + (MIN_SECS * {26'd0, minute_in_q})
                   + {26'd0, second_in_q};

  assign dp_stat_o.err      = err_q;
  assign dp_stat_o.year_fit = (acc_q < ylen);
  assign dp_stat_o.mon_fit  = (mon_q == LAST_MONTH) || (acc_q < mlen);
  assign dp_stat_o.yr_end   = (yy_q == year_in_q);
  assign dp_stat_o.mon_end  = (mon_q >= month_in_q);

  always_comb begin
    acc_d = acc_q;
    yy_d  = yy_q;
    mon_d = mon_q;
    dq_d  = dq_q;
    hq_d  = hq_q;
    mq_d  = mq_q;
    case (dp_cmd_i.op)
      OP_LOAD: begin
        mon_d = 4'd1;
        dq_d  = 5'd0;
        hq_d  = 5'd0;
        mq_d  = 6'd0;
        if (cmd_i) begin
          acc_d = (year_in_i < WINDOW_PIVOT) ? EPOCH_AT_2000 : 32'd0;
          yy_d  = (year_in_i < WINDOW_PIVOT) ? 7'd0 : WINDOW_PIVOT;
        end else if (epoch_in_i >= EPOCH_AT_2000) begin
          acc_d = epoch_in_i - EPOCH_AT_2000;
          yy_d  = 7'd0;
        end else begin
          acc_d = epoch_in_i;
          yy_d  = WINDOW_PIVOT;
        end
      end
      OP_YEAR_DN: begin
        acc_d = acc_q - ylen;
        yy_d  = yy_q + 7'd1;
      end
      OP_MON_DN: begin
        acc_d = acc_q - mlen;
        mon_d = mon_q + 4'd1;
      end
      OP_DIV_DAY: begin
        if (quot_step) dq_d = day_prod[28:24];
        else acc_d = acc_q - (DAY_SECS * {27'd0, dq_q});
      end
      OP_DIV_HOUR: begin
        if (quot_step) hq_d = hour_prod[24:20];
        else acc_d = acc_q - (HOUR_SECS * {27'd0, hq_q});
      end
      OP_DIV_MIN: begin
        if (quot_step) mq_d = min_prod[19:14];
        else acc_d = acc_q - (MIN_SECS * {26'd0, mq_q});
      end
      OP_YEAR_UP: begin
        acc_d = acc_q + ylen;
        yy_d  = yy_q + 7'd1;
      end
      OP_MON_UP: begin
        acc_d = acc_q + mlen;
        mon_d = mon_q + 4'd1;
      end
      OP_ADD_DAY:  acc_d = acc_q + day_term;
      OP_ADD_TIME: acc_d = acc_q + time_term;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= 1'b0;
      err_q <= 1'b0;
    end else if (dp_cmd_i.op == OP_LOAD) begin
      cmd_q <= cmd_i;
      err_q <= !cmd_i && (epoch_in_i >= EPOCH_AT_2070);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    yy_q  <= yy_d;
    mon_q <= mon_d;
    dq_q  <= dq_d;
    hq_q  <= hq_d;
    mq_q  <= mq_d;
    if (dp_cmd_i.op == OP_LOAD) begin
      year_in_q   <= year_in_i;
      month_in_q  <= month_in_i;
      day_in_q    <= day_in_i;
      hour_in_q   <= hour_in_i;
      minute_in_q <= minute_in_i;
      second_in_q <= second_in_i;
    end
  end

  // result register, zero fields outside the active direction
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.out_load) begin
      if (cmd_q) begin
        epoch_out_o   <= acc_q;
        year_out_o    <= 7'd0;
        month_out_o   <= 4'd0;
        day_out_o     <= 5'd0;
        hour_out_o    <= 5'd0;
        minute_out_o  <= 6'd0;
        second_out_o  <= 6'd0;
        range_error_o <= 1'b0;
      end else if (err_q) begin
        epoch_out_o   <= 32'd0;
        year_out_o    <= 7'd0;
        month_out_o   <= 4'd0;
        day_out_o     <= 5'd0;
        hour_out_o    <= 5'd0;
        minute_out_o  <= 6'd0;
        second_out_o  <= 6'd0;
        range_error_o <= 1'b1;
      end else begin
        epoch_out_o   <= 32'd0;
        year_out_o    <= yy_q;
        month_out_o   <= mon_q;
        day_out_o     <= dq_q + 5'd1;
        hour_out_o    <= hq_q;
        minute_out_o  <= mq_q;
        second_out_o  <= acc_q[5:0];
        range_error_o <= 1'b0;
      end
    end
  end

endmodule

// ===== src/escc_ctrl.sv =====
// controller: sequences the year, month, divide and add steps and owns the handshakes
module escc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  escc_pkg::dp_stat_t dp_stat_i,
  output escc_pkg::dp_cmd_t  dp_cmd_o
);
  import escc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_YEAR_DN  = 11'b00000000010,
    S_MON_DN   = 11'b00000000100,
    S_DIV_DAY  = 11'b00000001000,
    S_DIV_HOUR = 11'b00000010000,
    S_DIV_MIN  = 11'b00000100000,
    S_YEAR_UP  = 11'b00001000000,
    S_MON_UP   = 11'b00010000000,
    S_ADD_DAY  = 11'b00100000000,
    S_ADD_TIME = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    k_d               = k_q;
    dp_cmd_o.op       = OP_NONE;
    dp_cmd_o.k        = k_q;
    dp_cmd_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.op = OP_LOAD;
          state_d     = cmd_i ? S_YEAR_UP : S_YEAR_DN;
        end
      end
      S_YEAR_DN: begin
        if (dp_stat_i.err) begin
          state_d = S_DONE;
        end else if (dp_stat_i.year_fit) begin
          state_d = S_MON_DN;
        end else begin
          dp_cmd_o.op = OP_YEAR_DN;
        end
      end
      S_MON_DN: begin
        if (dp_stat_i.mon_fit) begin
          state_d = S_DIV_DAY;
          k_d     = DIV_FIRST_STEP;
        end else begin
          dp_cmd_o.op = OP_MON_DN;
        end
      end
      S_DIV_DAY: begin
        dp_cmd_o.op = OP_DIV_DAY;
        if (k_q == 3'd0) begin
          state_d = S_DIV_HOUR;
          k_d     = DIV_FIRST_STEP;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_DIV_HOUR: begin
        dp_cmd_o.op = OP_DIV_HOUR;
        if (k_q == 3'd0) begin
          state_d = S_DIV_MIN;
          k_d     = DIV_FIRST_STEP;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_DIV_MIN: begin
        dp_cmd_o.op = OP_DIV_MIN;
        if (k_q == 3'd0) begin
          state_d = S_DONE;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_YEAR_UP: begin
        if (dp_stat_i.yr_end) begin
          state_d = S_MON_UP;
        end else begin
          dp_cmd_o.op = OP_YEAR_UP;
        end
      end
      S_MON_UP: begin
        if (dp_stat_i.mon_end) begin
          state_d = S_ADD_DAY;
        end else begin
          dp_cmd_o.op = OP_MON_UP;
        end
      end
      S_ADD_DAY: begin
        dp_cmd_o.op = OP_ADD_DAY;
        state_d     = S_ADD_TIME;
      end
      S_ADD_TIME: begin
        dp_cmd_o.op = OP_ADD_TIME;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.out_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (dp_cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/epoch_seconds_calendar_convert_top.sv =====
// top level of the epoch seconds <-> calendar date converter
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+-------------------------------------------------
//   input    | in_valid_i/in_ready_o | cmd, epoch_in, year/month/day/hour/minute/second_in
//   output   | out_valid_o/out_ready_i | epoch_out, calendar fields, range_error
//
// one beat at a time; a beat's length is set mainly by the year walk
// (one year per cycle through the shared 32-bit adder), then the month steps and
// three reciprocal divides, each a quotient and a subtract step (seconds to calendar) or
// the month steps and two add steps (calendar to seconds), plus load and hand-off.
// reset returns the controller to idle with no result pending.
// a stalled output holds the result; the next input beat is taken once the result
// register has been loaded, even while that result still waits.
module epoch_seconds_calendar_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] epoch_in_i,
  input  logic [6:0]  year_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [4:0]  hour_in_i,
  input  logic [5:0]  minute_in_i,
  input  logic [5:0]  second_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] epoch_out_o,
  output logic [6:0]  year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic        range_error_o
);
  import escc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  escc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  escc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_stat_o     (dp_stat),
    .cmd_i         (cmd_i),
    .epoch_in_i    (epoch_in_i),
    .year_in_i     (year_in_i),
    .month_in_i    (month_in_i),
    .day_in_i      (day_in_i),
    .hour_in_i     (hour_in_i),
    .minute_in_i   (minute_in_i),
    .second_in_i   (second_in_i),
    .epoch_out_o   (epoch_out_o),
    .year_out_o    (year_out_o),
    .month_out_o   (month_out_o),
    .day_out_o     (day_out_o),
    .hour_out_o    (hour_out_o),
    .minute_out_o  (minute_out_o),
    .second_out_o  (second_out_o),
    .range_error_o (range_error_o)
  );

endmodule
